@@ design/bfe_pkg.sv @@
// bfe_pkg: shared types, codes and hash constants for the bloom filter engine
// no dependencies; imported by every bfe module
package bfe_pkg;

  typedef enum logic [1:0] {
    FUNC_GET   = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_SETNC = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  localparam logic REG_NUM_BITS   = 1'b0;
  localparam logic REG_NUM_HASHES = 1'b1;

  localparam logic [20:0] NUM_BITS_RESET   = 21'd1048576;
  localparam logic [4:0]  NUM_HASHES_RESET = 5'd4;

  localparam logic [63:0] MIX_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] ADD_H1 = 64'h0000000052dce729;
  localparam logic [63:0] ADD_H2 = 64'h0000000038495ab5;

  typedef struct packed {
    logic wr_en;
    logic flush;
    logic key_end;
  } kb_ctrl_t;

  typedef enum logic [4:0] {
    HS_IDLE, HS_NEXT, HS_RD, HS_LD, HS_MA, HS_MB, HS_UP1, HS_UP2,
    HS_FIN1, HS_FIN2, HS_FIN3, HS_FM0, HS_FM1, HS_FM2, HS_FIN4, HS_FIN5,
    HS_DONE
  } hash_state_t;

  typedef enum logic [3:0] {
    TS_CLR, TS_IN, TS_FLUSH, TS_DECIDE, TS_HASH, TS_HWAIT, TS_MOD,
    TS_PRD, TS_PEX, TS_NEXT, TS_RES
  } top_state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

@@ design/bfe_key_buf.sv @@
// bfe_key_buf: packs incoming key bytes into a word memory, tracks length and overflow
// depends on bfe_pkg
module bfe_key_buf #(
  parameter int MAX_KEY_WORDS = 32,
  localparam int KEY_CAP = 8 * MAX_KEY_WORDS,
  localparam int LEN_W = $clog2(KEY_CAP + 1),
  localparam int KW_AW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfe_pkg::kb_ctrl_t    ctrl,
  input  logic [63:0]          wr_word,
  input  logic [3:0]           wr_bytes,
  output logic [LEN_W-1:0]     key_len,
  output logic                 overflow,
  input  logic [KW_AW-1:0]     rd_addr,
  output logic [63:0]          rd_data
);
  import bfe_pkg::*;

  logic [63:0]      mem [MAX_KEY_WORDS];
  logic [63:0]      acc_r;
  logic [LEN_W-1:0] len_r;
  logic             ovf_r;
  logic [63:0]      rd_data_r;

  logic [3:0]       nb;
  logic [63:0]      wm;
  logic [127:0]     comb;
  logic [LEN_W:0]   sum;
  logic [3:0]       fill_sum;
  logic             fits, full, app, we;
  logic [KW_AW-1:0] wa;
  logic [63:0]      wd;

  always_comb begin
    nb = (wr_bytes > 4'd8) ? 4'd8 : wr_bytes;
    for (int b = 0; b < 8; b++) begin
      wm[8*b +: 8] = (4'(b) < nb) ? wr_word[8*b +: 8] : 8'h00;
    end
    // acc holds len mod 8 bytes, upper bytes always zero
    comb     = {64'h0, acc_r} | ({64'h0, wm} << {len_r[2:0], 3'b000});
    sum      = {1'b0, len_r} + (LEN_W+1)'(nb);
    fits     = sum <= (LEN_W+1)'(KEY_CAP);
    fill_sum = {1'b0, len_r[2:0]} + nb;
    full     = fill_sum[3];
    app      = ctrl.wr_en && !ovf_r && fits;
    wa       = len_r[KW_AW+2:3];
    we       = (app && full) || (ctrl.flush && !ovf_r && len_r[2:0] != 3'd0);
    wd       = app ? comb[63:0] : acc_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.key_end) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      acc_r <= '0;
    end else if (ctrl.wr_en && !ovf_r) begin
      if (!fits) begin
        ovf_r <= 1'b1;
      end else begin
        len_r <= sum[LEN_W-1:0];
        acc_r <= full ? comb[127:64] : comb[63:0];
      end
    end
  end

  assign key_len  = len_r;
  assign overflow = ovf_r;
  assign rd_data  = rd_data_r;

endmodule

@@ design/bfe_mul64.sv @@
// bfe_mul64: low 64 bits of a 64x64 product from three 32x32 partial products
// depends on bfe_pkg; result valid with done
module bfe_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  import bfe_pkg::*;

  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  ph_r;
  logic        busy_r, done_r;
  logic [31:0] op_x, op_y;
  logic [63:0] m;

  always_comb begin
    case (ph_r)
      2'd0:    begin op_x = a_r[31:0];  op_y = b_r[31:0];  end
      2'd1:    begin op_x = a_r[31:0];  op_y = b_r[63:32]; end
      default: begin op_x = a_r[63:32]; op_y = b_r[31:0];  end
    endcase
    m = op_x * op_y;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      // cross terms only reach the upper half
      acc_r <= (ph_r == 2'd0) ? m : acc_r + {m[31:0], 32'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        if (ph_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ design/bfe_mod.sv @@
// bfe_mod: restoring remainder of a 64-bit value by the filter size, one bit a cycle
// depends on bfe_pkg; remainder valid with done
module bfe_mod #(
  parameter int MAX_BITS = 1048576,
  localparam int BITS_W = $clog2(MAX_BITS + 1),
  localparam int IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       dividend,
  input  logic [BITS_W-1:0] modulus,
  output logic              done,
  output logic [IDX_W-1:0]  rem
);
  import bfe_pkg::*;

  logic [63:0]       x_r;
  logic [BITS_W-1:0] rem_r, m_r, rem_nxt;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic [BITS_W:0]   t, tsub;

  always_comb begin
    t       = {rem_r, x_r[63]};
    tsub    = t - {1'b0, m_r};
    rem_nxt = (t >= {1'b0, m_r}) ? tsub[BITS_W-1:0] : t[BITS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      m_r   <= modulus;
      rem_r <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[62:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[IDX_W-1:0];

endmodule

@@ design/bfe_hash.sv @@
// bfe_hash: seeded murmur3 x64_128 over the buffered key, one shared multiplier
// depends on bfe_pkg and bfe_mul64; reads the key buffer memory word by word
module bfe_hash #(
  parameter int MAX_KEY_WORDS = 32,
  parameter int MAX_HASHES = 16,
  localparam int SEED_W = $clog2(MAX_HASHES + 1),
  localparam int LEN_W = $clog2(8 * MAX_KEY_WORDS + 1),
  localparam int KW_AW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SEED_W-1:0] seed,
  input  logic [LEN_W-1:0]  key_len,
  output logic [KW_AW-1:0]  rd_addr,
  input  logic [63:0]       rd_data,
  output logic              done,
  output logic [63:0]       h1,
  output logic [63:0]       h2
);
  import bfe_pkg::*;

  hash_state_t      st_r, st_nxt;
  logic [63:0]      h1_r, h1_nxt, h2_r, h2_nxt;
  logic [LEN_W-1:0] blk_r, blk_nxt;
  logic             lane_r, lane_nxt, tail_r, tail_nxt, fsel_r, fsel_nxt;
  logic             mul_start, mul_done;
  logic [63:0]      mul_a, mul_b, mul_p;
  logic [LEN_W+3:0] len_ext;
  logic [LEN_W-1:0] blocks;
  logic [3:0]       rest;
  logic [LEN_W:0]   wa;
  logic [63:0]      kr, fsrc, fmix_p;

  bfe_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  assign len_ext = {4'b0, key_len};
  assign blocks  = len_ext[LEN_W+3:4];
  assign rest    = key_len[3:0];
  // lane 0 reads the even word of a block, lane 1 the odd one
  assign wa      = {blk_r, lane_r};
  assign rd_addr = wa[KW_AW-1:0];

  always_comb begin
    st_nxt    = st_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    blk_nxt   = blk_r;
    lane_nxt  = lane_r;
    tail_nxt  = tail_r;
    fsel_nxt  = fsel_r;
    mul_start = 1'b0;
    mul_a     = rd_data;
    mul_b     = MIX_C1;
    done      = 1'b0;
    kr        = lane_r ? rotl64(mul_p, 33) : rotl64(mul_p, 31);
    fsrc      = fsel_r ? h2_r : h1_r;
    fmix_p    = mul_p ^ (mul_p >> 33);
    unique case (st_r)
      HS_IDLE: begin
        if (start) begin
          h1_nxt   = 64'(seed);
          h2_nxt   = 64'(seed);
          blk_nxt  = '0;
          lane_nxt = 1'b0;
          tail_nxt = 1'b0;
          st_nxt   = HS_NEXT;
        end
      end
      HS_NEXT: begin
        if (blk_r != blocks) begin
          lane_nxt = 1'b0;
          st_nxt   = HS_RD;
        end else begin
          tail_nxt = 1'b1;
          if (rest > 4'd8) begin
            lane_nxt = 1'b1;
            st_nxt   = HS_RD;
          end else if (rest != 4'd0) begin
            lane_nxt = 1'b0;
            st_nxt   = HS_RD;
          end else begin
            st_nxt = HS_FIN1;
          end
        end
      end
      HS_RD: st_nxt = HS_LD;
      HS_LD: begin
        mul_start = 1'b1;
        mul_a     = rd_data;
        mul_b     = lane_r ? MIX_C2 : MIX_C1;
        st_nxt    = HS_MA;
      end
      HS_MA: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = kr;
          mul_b     = lane_r ? MIX_C1 : MIX_C2;
          st_nxt    = HS_MB;
        end
      end
      HS_MB: begin
        if (mul_done) begin
          if (lane_r) begin
            h2_nxt = h2_r ^ mul_p;
          end else begin
            h1_nxt = h1_r ^ mul_p;
          end
          if (!tail_r) begin
            st_nxt = HS_UP1;
          end else if (lane_r) begin
            // tail: upper half first, then the lower half
            lane_nxt = 1'b0;
            st_nxt   = HS_RD;
          end else begin
            st_nxt = HS_FIN1;
          end
        end
      end
      HS_UP1: begin
        if (lane_r) begin
          h2_nxt = rotl64(h2_r, 31) + h1_r;
        end else begin
          h1_nxt = rotl64(h1_r, 27) + h2_r;
        end
        st_nxt = HS_UP2;
      end
      HS_UP2: begin
        if (lane_r) begin
          h2_nxt   = (h2_r << 2) + h2_r + ADD_H2;
          lane_nxt = 1'b0;
          blk_nxt  = blk_r + 1'b1;
          st_nxt   = HS_NEXT;
        end else begin
          h1_nxt   = (h1_r << 2) + h1_r + ADD_H1;
          lane_nxt = 1'b1;
          st_nxt   = HS_RD;
        end
      end
      HS_FIN1: begin
        h1_nxt = h1_r ^ 64'(key_len);
        h2_nxt = h2_r ^ 64'(key_len);
        st_nxt = HS_FIN2;
      end
      HS_FIN2: begin
        h1_nxt = h1_r + h2_r;
        st_nxt = HS_FIN3;
      end
      HS_FIN3: begin
        h2_nxt   = h2_r + h1_r;
        fsel_nxt = 1'b0;
        st_nxt   = HS_FM0;
      end
      HS_FM0: begin
        mul_start = 1'b1;
        mul_a     = fsrc ^ (fsrc >> 33);
        mul_b     = FMIX_1;
        st_nxt    = HS_FM1;
      end
      HS_FM1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = fmix_p;
          mul_b     = FMIX_2;
          st_nxt    = HS_FM2;
        end
      end
      HS_FM2: begin
        if (mul_done) begin
          if (fsel_r) begin
            h2_nxt = fmix_p;
            st_nxt = HS_FIN4;
          end else begin
            h1_nxt   = fmix_p;
            fsel_nxt = 1'b1;
            st_nxt   = HS_FM0;
          end
        end
      end
      HS_FIN4: begin
        h1_nxt = h1_r + h2_r;
        st_nxt = HS_FIN5;
      end
      HS_FIN5: begin
        h2_nxt = h2_r + h1_r;
        st_nxt = HS_DONE;
      end
      HS_DONE: begin
        done   = 1'b1;
        st_nxt = HS_IDLE;
      end
      default: st_nxt = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= HS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h1_r   <= h1_nxt;
    h2_r   <= h2_nxt;
    blk_r  <= blk_nxt;
    lane_r <= lane_nxt;
    tail_r <= tail_nxt;
    fsel_r <= fsel_nxt;
  end

  assign h1 = h1_r;
  assign h2 = h2_r;

endmodule

@@ design/bloom_filter_engine.sv @@
// bloom_filter_engine: top level, control sequencer, bit store memory and result register
// depends on bfe_pkg, bfe_key_buf, bfe_hash, bfe_mod
//
// Usage: the key arrives on the in_ channel as 64-bit words, first byte lowest, with
// in_tdata carrying the valid byte count and in_tuser the operation (read on the word
// with in_tlast). Each last word yields one result word on the out_ channel; other words
// yield none. Configuration (filter size, hash count) is written on cfg_ while idle.
// Non-last words are taken one per cycle. After the last word the block is busy: get, and
//   set-if-absent with the key present, run one hash and remainder pass per hash, and
//   an inserted key runs the passes twice; the time grows with the hash count and the key
//   length, set by the bit-serial remainder and the shared multiplier. Clear and overlong
//   keys skip the hashing.
// Reset, and every clear, runs a pass that zeroes each of the ceil(MAX_BITS / 64) rows
// of the bit store (16384 at the default size), during which no word is taken.
// A result waits in the output register while the receiver stalls; the next key is
// taken meanwhile and only its own result waits for the register to free up.
module bloom_filter_engine #(
  parameter int MAX_BITS = 1048576,
  parameter int MAX_HASHES = 16,
  parameter int MAX_KEY_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // key_word [63:0], word_bytes [67:64], zero pad
  input  logic [1:0]  in_tuser,   // func [1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // present [0], inserted [1], element_total [33:2],
                                  // key_too_long [34], zero pad
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [20:0] cfg_wdata
);
  import bfe_pkg::*;

  localparam int BITS_W = $clog2(MAX_BITS + 1);
  localparam int IDX_W  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int ROWS   = (MAX_BITS + 63) / 64;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HS_W   = $clog2(MAX_HASHES + 1);
  localparam int LEN_W  = $clog2(8 * MAX_KEY_WORDS + 1);
  localparam int KW_AW  = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

  top_state_t        st_r, st_nxt;
  logic [20:0]       num_bits_r;
  logic [4:0]        num_hashes_r;
  func_t             func_r, func_nxt;
  logic              mark_r, mark_nxt, all_r, all_nxt, sel_r, sel_nxt;
  logic              present_r, present_nxt, inserted_r, inserted_nxt;
  logic              too_long_r, too_long_nxt, clr_pend_r, clr_pend_nxt;
  logic [HS_W-1:0]   seed_r, seed_nxt;
  logic [31:0]       count_r, count_nxt;
  logic [ROW_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_present_r, out_inserted_r, out_too_long_r;
  logic [31:0]       out_total_r;
  logic              out_load;

  logic [BITS_W-1:0] m_val;
  logic [HS_W-1:0]   k_val;
  logic [HS_W:0]     seed_inc;

  kb_ctrl_t          kb_ctrl;
  logic [LEN_W-1:0]  key_len;
  logic              key_ovf;
  logic [KW_AW-1:0]  kb_rd_addr;
  logic [63:0]       kb_rd_data;

  logic              hash_start, hash_done;
  logic [63:0]       hash_h1, hash_h2;
  logic              mod_start, mod_done_a, mod_done_b;
  logic [IDX_W-1:0]  rem_a, rem_b;

  logic [63:0]       bit_mem [ROWS];
  logic [63:0]       bm_rd_r;
  logic              bm_we;
  logic [ROW_AW-1:0] bm_wa, row_sel;
  logic [63:0]       bm_wd;
  logic [IDX_W+5:0]  pext;
  logic [5:0]        bpos;
  logic              probe_bit;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r   <= NUM_BITS_RESET;
      num_hashes_r <= NUM_HASHES_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr[0])
        REG_NUM_BITS:   num_bits_r   <= cfg_wdata;
        REG_NUM_HASHES: num_hashes_r <= cfg_wdata[4:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    if (32'(num_bits_r) < 32'd8) begin
      m_val = BITS_W'(8);
    end else if (32'(num_bits_r) > 32'(MAX_BITS)) begin
      m_val = BITS_W'(MAX_BITS);
    end else begin
      m_val = BITS_W'(num_bits_r);
    end
    if (num_hashes_r == 5'd0) begin
      k_val = HS_W'(1);
    end else if (32'(num_hashes_r) > 32'(MAX_HASHES)) begin
      k_val = HS_W'(MAX_HASHES);
    end else begin
      k_val = HS_W'(num_hashes_r);
    end
  end

  bfe_key_buf #(.MAX_KEY_WORDS(MAX_KEY_WORDS)) u_key_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (kb_ctrl),
    .wr_word  (in_tdata[63:0]),
    .wr_bytes (in_tdata[67:64]),
    .key_len  (key_len),
    .overflow (key_ovf),
    .rd_addr  (kb_rd_addr),
    .rd_data  (kb_rd_data)
  );

  bfe_hash #(.MAX_KEY_WORDS(MAX_KEY_WORDS), .MAX_HASHES(MAX_HASHES)) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .seed    (seed_r),
    .key_len (key_len),
    .rd_addr (kb_rd_addr),
    .rd_data (kb_rd_data),
    .done    (hash_done),
    .h1      (hash_h1),
    .h2      (hash_h2)
  );

  bfe_mod #(.MAX_BITS(MAX_BITS)) u_mod_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (hash_h1),
    .modulus  (m_val),
    .done     (mod_done_a),
    .rem      (rem_a)
  );

  bfe_mod #(.MAX_BITS(MAX_BITS)) u_mod_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (hash_h2),
    .modulus  (m_val),
    .done     (mod_done_b),
    .rem      (rem_b)
  );

  // bit store addressing: 64-bit rows
  always_comb begin
    pext      = {6'b0, (sel_r ? rem_b : rem_a)};
    row_sel   = pext[ROW_AW+5:6];
    bpos      = pext[5:0];
    probe_bit = bm_rd_r[bpos];
    bm_we     = (st_r == TS_CLR) || (st_r == TS_PEX && mark_r);
    bm_wa     = (st_r == TS_CLR) ? clr_cnt_r : row_sel;
    bm_wd     = (st_r == TS_CLR) ? 64'h0 : (bm_rd_r | (64'h1 << bpos));
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bit_mem[bm_wa] <= bm_wd;
    end
    bm_rd_r <= bit_mem[row_sel];
  end

  assign seed_inc  = {1'b0, seed_r} + 1'b1;
  assign in_tready = (st_r == TS_IN);

  always_comb begin
    st_nxt        = st_r;
    func_nxt      = func_r;
    mark_nxt      = mark_r;
    all_nxt       = all_r;
    sel_nxt       = sel_r;
    present_nxt   = present_r;
    inserted_nxt  = inserted_r;
    too_long_nxt  = too_long_r;
    clr_pend_nxt  = clr_pend_r;
    seed_nxt      = seed_r;
    count_nxt     = count_r;
    clr_cnt_nxt   = clr_cnt_r;
    kb_ctrl       = '0;
    hash_start    = 1'b0;
    mod_start     = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (st_r)
      TS_CLR: begin
        if (clr_cnt_r == ROW_AW'(ROWS - 1)) begin
          clr_cnt_nxt = '0;
          st_nxt      = TS_IN;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      TS_IN: begin
        if (in_tvalid) begin
          kb_ctrl.wr_en = 1'b1;
          if (in_tlast) begin
            func_nxt = func_t'(in_tuser);
            st_nxt   = TS_FLUSH;
          end
        end
      end
      TS_FLUSH: begin
        kb_ctrl.flush = 1'b1;
        st_nxt        = TS_DECIDE;
      end
      TS_DECIDE: begin
        too_long_nxt = key_ovf;
        present_nxt  = 1'b0;
        inserted_nxt = 1'b0;
        if (key_ovf) begin
          st_nxt = TS_RES;
        end else if (func_r == FUNC_CLEAR) begin
          count_nxt    = '0;
          clr_pend_nxt = 1'b1;
          st_nxt       = TS_RES;
        end else begin
          mark_nxt = 1'b0;
          all_nxt  = 1'b1;
          seed_nxt = '0;
          st_nxt   = TS_HASH;
        end
      end
      TS_HASH: begin
        hash_start = 1'b1;
        st_nxt     = TS_HWAIT;
      end
      TS_HWAIT: begin
        if (hash_done) begin
          mod_start = 1'b1;
          st_nxt    = TS_MOD;
        end
      end
      TS_MOD: begin
        if (mod_done_a && mod_done_b) begin
          sel_nxt = 1'b0;
          st_nxt  = TS_PRD;
        end
      end
      TS_PRD: st_nxt = TS_PEX;
      TS_PEX: begin
        if (!mark_r) begin
          all_nxt = all_r && probe_bit;
        end
        if (!sel_r) begin
          sel_nxt = 1'b1;
          st_nxt  = TS_PRD;
        end else begin
          st_nxt = TS_NEXT;
        end
      end
      TS_NEXT: begin
        if (seed_inc != {1'b0, k_val}) begin
          seed_nxt = seed_inc[HS_W-1:0];
          st_nxt   = TS_HASH;
        end else if (!mark_r) begin
          present_nxt = all_r;
          if (func_r == FUNC_SETNC || (func_r == FUNC_SET && !all_r)) begin
            mark_nxt = 1'b1;
            seed_nxt = '0;
            st_nxt   = TS_HASH;
          end else begin
            st_nxt = TS_RES;
          end
        end else begin
          inserted_nxt = 1'b1;
          if (count_r != 32'hFFFF_FFFF) begin
            count_nxt = count_r + 32'd1;
          end
          st_nxt = TS_RES;
        end
      end
      TS_RES: begin
        kb_ctrl.key_end = 1'b1;
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          clr_pend_nxt  = 1'b0;
          st_nxt        = clr_pend_r ? TS_CLR : TS_IN;
        end
      end
      default: st_nxt = TS_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= TS_CLR;
      clr_cnt_r   <= '0;
      clr_pend_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_pend_r  <= clr_pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    mark_r     <= mark_nxt;
    all_r      <= all_nxt;
    sel_r      <= sel_nxt;
    present_r  <= present_nxt;
    inserted_r <= inserted_nxt;
    too_long_r <= too_long_nxt;
    seed_r     <= seed_nxt;
    if (out_load) begin
      out_present_r  <= present_r;
      out_inserted_r <= inserted_r;
      out_total_r    <= count_r;
      out_too_long_r <= too_long_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_too_long_r, out_total_r, out_inserted_r, out_present_r};

endmodule
